// File: rtl/channel_swizzle_unorm_pack_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef CHANNEL_SWIZZLE_UNORM_PACK_MACROS_SVH
`define CHANNEL_SWIZZLE_UNORM_PACK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSWZ_HOLDS(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond)) else $error("channel swizzle check failed");
`define CSWZ_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (pre) |=> (post)) else $error("channel swizzle sequence check failed");
`else
`define CSWZ_HOLDS(lbl, cond)
`define CSWZ_NEXT(lbl, pre, post)
`endif
`endif

// File: rtl/cswz_pkg.sv
package cswz_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int IDX_W = 5;
    localparam int CNT_W = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [31:0] BITS_ZERO = 32'h0000_0000;
    localparam logic [31:0] BITS_ONE = 32'h3F80_0000;

    localparam logic [CFG_ADDR_W-1:0] REG_RED = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COUNT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOAT = 3'd5;

    typedef struct packed {
        logic [31:0] chan_0;
        logic [31:0] chan_1;
        logic [31:0] chan_2;
        logic [31:0] chan_3;
        logic [31:0] chan_4;
        logic [31:0] chan_5;
        logic [31:0] chan_6;
        logic [31:0] chan_7;
        logic        pixel_last;
    } cswz_in_t;

    typedef struct packed {
        logic [31:0] out_red;
        logic [31:0] out_green;
        logic [31:0] out_blue;
        logic [31:0] out_alpha;
        logic        out_last;
    } cswz_out_t;

    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } cswz_en_t;

endpackage

// File: rtl/cswz_lane.sv
module cswz_lane
    import cswz_pkg::*;
(
    input  logic        clk,
    input  cswz_en_t    en,
    input  logic [31:0] word,
    input  logic        float_mode,
    output logic [31:0] result
);

    localparam logic [35:0] HALF_FX = 36'h000_4000_000;

    logic [31:0] raw2_reg, raw3_reg, raw4_reg;
    logic [31:0] prod2_reg;
    logic [3:0]  sh2_reg;
    logic        zero2_reg, zero3_reg;
    logic        sat2_reg, sat3_reg;
    logic [35:0] u3_reg;
    logic [7:0]  byte4_reg;

    logic [31:0] prod2_next;
    logic [3:0]  sh2_next;
    logic        zero2_next, sat2_next, nan_w;
    logic [35:0] u3_next;
    logic [7:0]  byte4_next;

    logic        up3;
    logic [32:0] pr3;
    logic [35:0] t3;

    logic [5:0]  lead4;
    logic [3:0]  idx4;
    logic [36:0] u37, mask4, half4, rem4, r4;
    logic        up4;
    logic [9:0]  int4;

    always_comb
    begin
        nan_w = (word[30:23] == 8'hFF) && (word[22:0] != 23'd0);
        zero2_next = word[31] || nan_w || (word[30:23] < 8'd117);
        sat2_next = !word[31] && !nan_w && (word[30:23] >= 8'd127);
        sh2_next = 4'(word[30:23] - 8'd117);
        prod2_next = 32'({1'b1, word[22:0]}) * 32'd255;
    end

    always_comb
    begin
        if (prod2_reg[31])
        begin
            up3 = prod2_reg[7] && (prod2_reg[8] || (|prod2_reg[6:0]));
            pr3 = {1'b0, prod2_reg[31:8], 8'd0} + (up3 ? 33'd256 : 33'd0);
        end
        else
        begin
            up3 = prod2_reg[6] && (prod2_reg[7] || (|prod2_reg[5:0]));
            pr3 = {1'b0, prod2_reg[31:7], 7'd0} + (up3 ? 33'd128 : 33'd0);
        end
        t3 = 36'(pr3[32:6]) << sh2_reg;
        u3_next = t3 + HALF_FX;
    end

    always_comb
    begin
        lead4 = 6'd26;
        for (int i = 26; i <= 34; i++)
        begin
            if (u3_reg[i])
            begin
                lead4 = 6'(i);
            end
        end
        idx4 = 4'(lead4 - 6'd23);
        u37 = {1'b0, u3_reg};
        mask4 = (37'd1 << idx4) - 37'd1;
        half4 = 37'd1 << (idx4 - 4'd1);
        rem4 = u37 & mask4;
        up4 = (rem4 > half4) || ((rem4 == half4) && u37[idx4]);
        r4 = (u37 & ~mask4) + (up4 ? (mask4 + 37'd1) : 37'd0);
        int4 = r4[36:27];
        if (zero3_reg)
        begin
            byte4_next = 8'd0;
        end
        else if (sat3_reg || (int4 >= 10'd255))
        begin
            byte4_next = 8'd255;
        end
        else
        begin
            byte4_next = int4[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en2)
        begin
            raw2_reg <= word;
            prod2_reg <= prod2_next;
            sh2_reg <= sh2_next;
            zero2_reg <= zero2_next;
            sat2_reg <= sat2_next;
        end
        if (en.en3)
        begin
            raw3_reg <= raw2_reg;
            u3_reg <= u3_next;
            zero3_reg <= zero2_reg;
            sat3_reg <= sat2_reg;
        end
        if (en.en4)
        begin
            raw4_reg <= raw3_reg;
            byte4_reg <= byte4_next;
        end
    end

    assign result = float_mode ? raw4_reg : {24'd0, byte4_reg};

endmodule

// File: rtl/channel_swizzle_unorm_pack.sv
// Swizzles one pixel of up to eight fp32 channels into RGBA and, in byte mode, converts each
// word to an 8-bit unorm value. A pixel is taken every clock unless in_stall is high; each pixel
// passes through the register stages in order (channel select, multiply by 255, round and add one
// half, round and clamp), and any stage whose successor is free advances even while the
// output is stalled.
`include "channel_swizzle_unorm_pack_macros.svh"
module channel_swizzle_unorm_pack
    import cswz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cswz_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cswz_out_t             out_data,
    input  logic                  cfg_write_en,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [IDX_W-1:0] red_idx_reg, green_idx_reg, blue_idx_reg, alpha_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             float_reg;

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic             rdy1, rdy2, rdy3, rdy4;
    logic [31:0]      px1_reg [4];
    logic [31:0]      px1_next [4];
    logic [31:0]      px4 [4];
    logic             last1_reg, last2_reg, last3_reg, last4_reg;
    logic             fm1_reg, fm2_reg, fm3_reg, fm4_reg;
    logic [31:0]      chans [MAX_CHANNELS];
    cswz_en_t         lane_en;

    function automatic logic held(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt);
        held = !idx[IDX_W-1] && ({1'b0, idx[IDX_W-2:0]} < {1'b0, cnt})
               && (idx[IDX_W-2:0] < 4'(MAX_CHANNELS));
    endfunction

    always_comb
    begin
        chans[0] = in_data.chan_0;
        chans[1] = in_data.chan_1;
        chans[2] = in_data.chan_2;
        chans[3] = in_data.chan_3;
        chans[4] = in_data.chan_4;
        chans[5] = in_data.chan_5;
        chans[6] = in_data.chan_6;
        chans[7] = in_data.chan_7;
        px1_next[0] = held(red_idx_reg, count_reg) ? chans[red_idx_reg[2:0]] : BITS_ZERO;
        px1_next[1] = held(green_idx_reg, count_reg) ? chans[green_idx_reg[2:0]] : px1_next[0];
        px1_next[2] = held(blue_idx_reg, count_reg) ? chans[blue_idx_reg[2:0]] : px1_next[0];
        px1_next[3] = held(alpha_idx_reg, count_reg) ? chans[alpha_idx_reg[2:0]] : BITS_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_idx_reg <= 5'd0;
            green_idx_reg <= 5'h1F;
            blue_idx_reg <= 5'h1F;
            alpha_idx_reg <= 5'h1F;
            count_reg <= 4'd1;
            float_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_RED: red_idx_reg <= cfg_data;
                REG_GREEN: green_idx_reg <= cfg_data;
                REG_BLUE: blue_idx_reg <= cfg_data;
                REG_ALPHA: alpha_idx_reg <= cfg_data;
                REG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                REG_FLOAT: float_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign lane_en = '{en2: rdy2, en3: rdy3, en4: rdy4};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            px1_reg <= px1_next;
            last1_reg <= in_data.pixel_last;
            fm1_reg <= float_reg;
        end
        if (rdy2)
        begin
            last2_reg <= last1_reg;
            fm2_reg <= fm1_reg;
        end
        if (rdy3)
        begin
            last3_reg <= last2_reg;
            fm3_reg <= fm2_reg;
        end
        if (rdy4)
        begin
            last4_reg <= last3_reg;
            fm4_reg <= fm3_reg;
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        cswz_lane u_lane (
            .clk        (clk),
            .en         (lane_en),
            .word       (px1_reg[g]),
            .float_mode (fm4_reg),
            .result     (px4[g])
        );
    end

    assign out_valid = v4_reg;
    assign out_data = '{out_red: px4[0], out_green: px4[1], out_blue: px4[2],
                        out_alpha: px4[3], out_last: last4_reg};

    `CSWZ_NEXT(a_in_taken, in_valid && !in_stall, v1_reg)
    `CSWZ_NEXT(a_no_drop, v3_reg && !rdy4, v3_reg && v4_reg)
    `CSWZ_HOLDS(a_bubble_free, !v1_reg |-> !in_stall)
    `CSWZ_HOLDS(a_byte_clear, (v4_reg && !fm4_reg) |-> (px4[0][31:8] == 24'd0))

endmodule

// File: tb/sv/tb_channel_swizzle_unorm_pack.sv
`timescale 1ns / 1ps
module tb_channel_swizzle_unorm_pack;
    import cswz_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    cswz_in_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    cswz_out_t             out_data;
    logic                  cfg_write_en;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    channel_swizzle_unorm_pack i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the swizzle registers.
    logic [IDX_W-1:0] sel_red;
    logic [IDX_W-1:0] sel_green;
    logic [IDX_W-1:0] sel_blue;
    logic [IDX_W-1:0] sel_alpha;
    logic [CNT_W-1:0] sel_count;
    logic             sel_float;

    cswz_in_t  pixel_q[$];
    cswz_out_t rgba_q[$];
    int        mismatches;
    int        send_gap;
    int        recv_gap;
    int        g;
    int        s;
    bit        calm;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

    function automatic real pow2(input int n);
        real r;
        r = 1.0;
        if (n > 0)
            repeat (n) r = r * 2.0;
        else
            repeat (-n) r = r / 2.0;
        return r;
    endfunction

    // Rounds a double to the nearest fp32 value, ties to even.
    function automatic real round_fp32(input real x);
        real a;
        real ulp;
        real q;
        real f;
        real d;
        int  e;
        if (x == 0.0)
            return x;
        a = (x < 0.0) ? -x : x;
        e = 20;
        while (e > -126 && pow2(e) > a)
            e--;
        ulp = pow2(e - 23);
        q = a / ulp;
        f = $floor(q);
        d = q - f;
        if (d > 0.5 || (d == 0.5 && ($rtoi(f) % 2) == 1))
            f = f + 1.0;
        return (x < 0.0) ? -f * ulp : f * ulp;
    endfunction

    function automatic logic [31:0] to_byte(input logic [31:0] bits);
        logic [7:0] ex;
        real        p;
        real        t;
        real        u;
        ex = bits[30:23];
        if (ex == 8'hFF)
            return (bits[22:0] != 0 || bits[31]) ? 32'd0 : 32'd255;
        if (ex >= 8'd135)
            return bits[31] ? 32'd0 : 32'd255;
        if (ex == 0)
            p = $itor(bits[22:0]) * 255.0 * pow2(-149);
        else
            p = $itor({1'b1, bits[22:0]}) * 255.0 * pow2(int'(ex) - 150);
        if (bits[31])
            p = -p;
        if (p >= 256.0)
            return 32'd255;
        if (p <= -1.0)
            return 32'd0;
        t = round_fp32(p);
        u = round_fp32(t + 0.5);
        if (u < 0.0)
            return 32'd0;
        if (u >= 255.0)
            return 32'd255;
        return 32'($rtoi(u));
    endfunction

    function automatic logic [31:0] pick_channel(input cswz_in_t px, input logic [IDX_W-1:0] idx,
                                                 input logic [31:0] fallback);
        logic [31:0] ch[MAX_CHANNELS];
        ch = '{px.chan_0, px.chan_1, px.chan_2, px.chan_3,
               px.chan_4, px.chan_5, px.chan_6, px.chan_7};
        if (idx[IDX_W-1] || idx >= {1'b0, sel_count} || idx >= MAX_CHANNELS)
            return fallback;
        return ch[idx[2:0]];
    endfunction

    function automatic cswz_out_t swizzle_pixel(input cswz_in_t px);
        cswz_out_t r;
        r.out_red   = pick_channel(px, sel_red, BITS_ZERO);
        r.out_green = pick_channel(px, sel_green, r.out_red);
        r.out_blue  = pick_channel(px, sel_blue, r.out_red);
        r.out_alpha = pick_channel(px, sel_alpha, BITS_ONE);
        if (!sel_float)
        begin
            r.out_red   = to_byte(r.out_red);
            r.out_green = to_byte(r.out_green);
            r.out_blue  = to_byte(r.out_blue);
            r.out_alpha = to_byte(r.out_alpha);
        end
        r.out_last = px.pixel_last;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    // Driver: items leave the pending queue with a random gap between them, or none while calm is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            g = -1;
            if (in_valid && !in_stall)
            begin
                rgba_q.push_back(swizzle_pixel(in_data));
                g = calm ? 0 : $urandom_range(0, 4);
            end
            else if (!in_valid)
                g = send_gap;
            if (g >= 0)
            begin
                if (g == 0 && pixel_q.size() > 0)
                begin
                    in_data  <= pixel_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    send_gap <= (g > 0) ? g - 1 : 0;
                end
            end
        end
    end

    // Monitor: checks each result and stalls the output at random, or never while calm is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (rgba_q.size() == 0)
                report("unexpected item", out_data.out_red, 32'd0);
            else
            begin
                cswz_out_t w;
                w = rgba_q.pop_front();
                if (out_data.out_red !== w.out_red)
                    report("out_red", out_data.out_red, w.out_red);
                if (out_data.out_green !== w.out_green)
                    report("out_green", out_data.out_green, w.out_green);
                if (out_data.out_blue !== w.out_blue)
                    report("out_blue", out_data.out_blue, w.out_blue);
                if (out_data.out_alpha !== w.out_alpha)
                    report("out_alpha", out_data.out_alpha, w.out_alpha);
                if (out_data.out_last !== w.out_last)
                    report("out_last", 32'(out_data.out_last), 32'(w.out_last));
            end
            s = calm ? 0 : $urandom_range(0, 4);
            out_stall <= (s > 0);
            recv_gap  <= (s > 0) ? s - 1 : 0;
        end
        else if (recv_gap > 0)
        begin
            out_stall <= 1'b1;
            recv_gap  <= recv_gap - 1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            REG_RED:   sel_red = val;
            REG_GREEN: sel_green = val;
            REG_BLUE:  sel_blue = val;
            REG_ALPHA: sel_alpha = val;
            REG_COUNT: sel_count = val[CNT_W-1:0];
            REG_FLOAT: sel_float = val[0];
            default: ;
        endcase
    endtask

    task automatic set_swizzle(input int r, input int gr, input int b, input int a,
                               input int cnt, input bit fl);
        write_reg(REG_RED, CFG_DATA_W'(r));
        write_reg(REG_GREEN, CFG_DATA_W'(gr));
        write_reg(REG_BLUE, CFG_DATA_W'(b));
        write_reg(REG_ALPHA, CFG_DATA_W'(a));
        write_reg(REG_COUNT, CFG_DATA_W'(cnt));
        write_reg(REG_FLOAT, CFG_DATA_W'(fl));
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pixel_q.size() != 0 || in_valid || rgba_q.size() != 0);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [31:0] channel_value();
        logic [31:0] specials[14];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                     32'h3F00_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                     32'hFFFF_FFFF, 32'h0000_0001, 32'h437F_0000, 32'h3F7F_FFFF,
                     32'h3B00_8081, 32'hBB00_0000};
        case ($urandom_range(0, 3))
            0: return specials[$urandom_range(0, 13)];
            1: return $urandom();
            default: return {$urandom_range(0, 1) == 0 ? 1'b0 : 1'b1,
                             8'($urandom_range(112, 127)), 23'($urandom())};
        endcase
    endfunction

    function automatic cswz_in_t random_pixel();
        cswz_in_t p;
        p.chan_0 = channel_value();
        p.chan_1 = channel_value();
        p.chan_2 = channel_value();
        p.chan_3 = channel_value();
        p.chan_4 = channel_value();
        p.chan_5 = channel_value();
        p.chan_6 = channel_value();
        p.chan_7 = channel_value();
        p.pixel_last = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic queue_pixels(input int n);
        repeat (n) pixel_q.push_back(random_pixel());
    endtask

    function automatic int random_index();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
    endfunction

    initial
    begin
        cswz_in_t p;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        calm         = 1'b0;
        sel_red      = 5'd0;
        sel_green    = 5'h1F;
        sel_blue     = 5'h1F;
        sel_alpha    = 5'h1F;
        sel_count    = 4'd1;
        sel_float    = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: luminance from channel zero, opaque alpha.
        queue_pixels(3);
        wait_idle();

        // All channels held, byte mode, with the conversion extremes.
        set_swizzle(0, 1, 2, 3, 8, 1'b0);
        p = '{32'h0000_0000, 32'h3F80_0000, 32'h7FC0_0000, 32'h7F80_0000,
              32'hFF80_0000, 32'h3F00_0000, 32'hBF80_0000, 32'h8000_0000, 1'b1};
        pixel_q.push_back(p);
        p = '{32'h3F7F_FFFF, 32'h3B00_8081, 32'h437F_0000, 32'h0000_0001,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h3C00_0000, 32'h3F7E_FEFF, 1'b0};
        pixel_q.push_back(p);
        queue_pixels(3);
        wait_idle();

        // Upper channels, float mode.
        set_swizzle(7, 6, 5, 4, 8, 1'b1);
        queue_pixels(3);
        wait_idle();
        // Indices at the count and beyond the channel limit.
        set_swizzle(8, 15, 3, 2, 3, 1'b0);
        queue_pixels(3);
        wait_idle();
        // Most negative index and an oversized count.
        set_swizzle(-16, -1, 1, -1, 15, 1'b1);
        queue_pixels(3);
        wait_idle();
        // No channel at all.
        set_swizzle(0, 1, 2, 3, 0, 1'b0);
        queue_pixels(3);
        wait_idle();
        set_swizzle(-1, -1, -1, 0, 9, 1'b1);
        queue_pixels(3);
        wait_idle();

        for (int ph = 0; ph < 14; ph++)
        begin
            calm = (ph % 4 == 3);
            set_swizzle(random_index(), random_index(), random_index(), random_index(),
                        $urandom_range(0, 15), $urandom_range(0, 2) == 0);
            queue_pixels(60);
            wait_idle();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
